// ===== design/hba_pkg.sv =====
// shared types, codes and helpers for the hierarchical bitmap allocator
`default_nettype none
package hba_pkg;

    localparam int WORD_BITS = 32;
    localparam int Q_DEPTH   = 2;

    typedef enum logic [2:0] {
        CMD_ANY   = 3'd0,
        CMD_TAKE  = 3'd1,
        CMD_GIVE  = 3'd2,
        CMD_QUERY = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_FULL     = 3'd2,
        ST_USED     = 3'd3,
        ST_NOT_USED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        K_ANY,
        K_TAKE,
        K_GIVE,
        K_QUERY,
        K_CLEAR,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [14:0] idx;
        logic [15:0] lim;
        t_status     status;
    } t_job;

    // position of the lowest set bit, zero for an empty word
    function automatic logic [4:0] f_low_bit(input logic [31:0] w);
        logic [4:0] p;
        p = '0;
        for (int i = 31; i >= 0; i--) begin
            if (w[i]) p = 5'(i);
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== design/hba_cmd_if.sv =====
// command channel interface
`default_nettype none
interface hba_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [14:0] slot_index;

    modport source (output valid, output command, output slot_index, input ready);
    modport sink   (input valid, input command, input slot_index, output ready);
endinterface
`default_nettype wire

// ===== design/hba_res_if.sv =====
// result channel interface
`default_nettype none
interface hba_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [14:0] granted_index;
    logic        is_free;
    logic [15:0] used_count;

    modport source (output valid, output status, output granted_index, output is_free,
                    output used_count, input ready);
    modport sink   (input valid, input status, input granted_index, input is_free,
                    input used_count, output ready);
endinterface
`default_nettype wire

// ===== design/hba_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module hba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/hba_front.sv =====
// front end: accepts commands, range checks them and queues jobs
`default_nettype none
module hba_front #(
    parameter int CAPACITY = 32768
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    hba_cmd_if.sink            i_cmd,
    input  wire logic [15:0]   i_entry_limit,
    input  wire logic          i_busy,
    output logic               o_job_valid,
    output hba_pkg::t_job      o_job,
    input  wire logic          i_job_pop
);
    import hba_pkg::*;

    t_job        r_q [Q_DEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    logic [15:0] lim;
    logic        in_range;
    t_job        job_in;

    assign lim      = (32'(i_entry_limit) > CAPACITY) ? 16'(CAPACITY) : i_entry_limit;
    assign in_range = 16'(i_cmd.slot_index) < lim;

    always_comb begin
        job_in.idx    = i_cmd.slot_index;
        job_in.lim    = lim;
        job_in.status = ST_OK;
        job_in.kind   = K_NONE;
        unique case (i_cmd.command)
            CMD_ANY:   job_in.kind = K_ANY;
            CMD_TAKE:  job_in.kind = in_range ? K_TAKE : K_NONE;
            CMD_GIVE:  job_in.kind = in_range ? K_GIVE : K_NONE;
            CMD_QUERY: job_in.kind = in_range ? K_QUERY : K_NONE;
            CMD_CLEAR: job_in.kind = K_CLEAR;
            default:   job_in.kind = K_NONE;
        endcase
        if (!in_range && (i_cmd.command == CMD_TAKE || i_cmd.command == CMD_GIVE ||
                          i_cmd.command == CMD_QUERY)) begin
            job_in.status = ST_RANGE;
        end
    end

    assign i_cmd.ready = (r_cnt != 2'(Q_DEPTH)) && !i_busy;
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_job_valid = r_cnt != 2'd0;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_job_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_job_pop);
        end
    end
endmodule
`default_nettype wire

// ===== design/hba_back.sv =====
// back end: walks and updates the three bitmap levels, holds the result register
`default_nettype none
module hba_back #(
    parameter int CAPACITY = 32768
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  hba_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_busy,
    hba_res_if.source          o_res
);
    import hba_pkg::*;

    localparam int LEAF_DEPTH = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int MID_DEPTH  = (LEAF_DEPTH + WORD_BITS - 1) / WORD_BITS;
    localparam int LAW        = LEAF_DEPTH > 1 ? $clog2(LEAF_DEPTH) : 1;
    localparam int MAW        = MID_DEPTH > 1 ? $clog2(MID_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_TOP, S_MID, S_LEAF, S_EXEC, S_SWEEP, S_DONE
    } t_state;

    t_state      r_state, n_state;
    t_job        r_job, n_job;
    logic [31:0] r_top, n_top;
    logic [15:0] r_count, n_count;
    logic [4:0]  r_m, n_m;
    logic [9:0]  r_l, n_l;
    logic [31:0] r_mid_word, n_mid_word;
    logic [LAW-1:0] r_sweep, n_sweep;
    logic        r_init, n_init;
    t_status     r_st, n_st;
    logic [14:0] r_granted, n_granted;
    logic        r_free, n_free;
    logic        r_out_valid, n_out_valid;
    t_status     r_o_status, n_o_status;
    logic [14:0] r_o_granted, n_o_granted;
    logic        r_o_free, n_o_free;
    logic [15:0] r_o_count, n_o_count;

    logic            leaf_we, mid_we;
    logic [LAW-1:0]  leaf_waddr, leaf_raddr;
    logic [MAW-1:0]  mid_waddr, mid_raddr;
    logic [31:0]     leaf_wdata, mid_wdata, leaf_rdata, mid_rdata;

    logic [4:0]  cur_m, low_mid, low_leaf, eb, el, em;
    logic [9:0]  cur_l;
    logic [14:0] cur_g;
    logic [31:0] new_leaf, new_mid;

    hba_ram #(.WIDTH(32), .DEPTH(LEAF_DEPTH)) u_leaf (
        .i_clk(i_clk), .i_we(leaf_we), .i_waddr(leaf_waddr), .i_wdata(leaf_wdata),
        .i_raddr(leaf_raddr), .o_rdata(leaf_rdata)
    );
    hba_ram #(.WIDTH(32), .DEPTH(MID_DEPTH)) u_mid (
        .i_clk(i_clk), .i_we(mid_we), .i_waddr(mid_waddr), .i_wdata(mid_wdata),
        .i_raddr(mid_raddr), .o_rdata(mid_rdata)
    );

    assign cur_m    = f_low_bit(r_top);
    assign low_mid  = f_low_bit(mid_rdata);
    assign low_leaf = f_low_bit(leaf_rdata);
    assign cur_l    = {r_m, low_mid};
    assign cur_g    = {r_l, low_leaf};
    assign eb       = r_job.idx[4:0];
    assign el       = r_job.idx[9:5];
    assign em       = r_job.idx[14:10];

    assign o_busy              = r_init;
    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_o_status;
    assign o_res.granted_index = r_o_granted;
    assign o_res.is_free       = r_o_free;
    assign o_res.used_count    = r_o_count;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_top       = r_top;
        n_count     = r_count;
        n_m         = r_m;
        n_l         = r_l;
        n_mid_word  = r_mid_word;
        n_sweep     = r_sweep;
        n_init      = r_init;
        n_st        = r_st;
        n_granted   = r_granted;
        n_free      = r_free;
        n_out_valid = r_out_valid && !o_res.ready;
        n_o_status  = r_o_status;
        n_o_granted = r_o_granted;
        n_o_free    = r_o_free;
        n_o_count   = r_o_count;
        o_job_pop   = 1'b0;
        leaf_we     = 1'b0;
        leaf_waddr  = '0;
        leaf_wdata  = '0;
        leaf_raddr  = '0;
        mid_we      = 1'b0;
        mid_waddr   = '0;
        mid_wdata   = '0;
        mid_raddr   = '0;
        new_leaf    = '0;
        new_mid     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_st      = i_job.status;
                    n_granted = i_job.idx;
                    n_free    = 1'b0;
                    // given index ops read both words of its path right away
                    leaf_raddr = LAW'(i_job.idx[14:5]);
                    mid_raddr  = MAW'(i_job.idx[14:10]);
                    unique case (i_job.kind)
                        K_ANY:   n_state = S_TOP;
                        K_TAKE, K_GIVE, K_QUERY: n_state = S_EXEC;
                        K_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_TOP: begin
                if (r_count >= r_job.lim || r_top == '0 || 32'(cur_m) >= MID_DEPTH) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    mid_raddr = MAW'(cur_m);
                    n_m       = cur_m;
                    n_state   = S_MID;
                end
            end
            S_MID: begin
                if (mid_rdata == '0 || 32'(cur_l) >= LEAF_DEPTH) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    leaf_raddr = LAW'(cur_l);
                    n_l        = cur_l;
                    n_mid_word = mid_rdata;
                    n_state    = S_LEAF;
                end
            end
            S_LEAF: begin
                n_state = S_DONE;
                if (leaf_rdata == '0 || 32'(cur_g) >= CAPACITY) begin
                    n_st = ST_FULL;
                end else begin
                    new_leaf   = leaf_rdata & ~(32'd1 << low_leaf);
                    leaf_we    = 1'b1;
                    leaf_waddr = LAW'(r_l);
                    leaf_wdata = new_leaf;
                    if (new_leaf == '0) begin
                        new_mid   = r_mid_word & ~(32'd1 << r_l[4:0]);
                        mid_we    = 1'b1;
                        mid_waddr = MAW'(r_m);
                        mid_wdata = new_mid;
                        if (new_mid == '0) n_top = r_top & ~(32'd1 << r_m);
                    end
                    n_count   = r_count + 16'd1;
                    n_granted = cur_g;
                end
            end
            S_EXEC: begin
                n_state    = S_DONE;
                leaf_waddr = LAW'(r_job.idx[14:5]);
                mid_waddr  = MAW'(r_job.idx[14:10]);
                case (r_job.kind)
                    K_TAKE: begin
                        if (!leaf_rdata[eb]) begin
                            n_st = ST_USED;
                        end else begin
                            new_leaf   = leaf_rdata & ~(32'd1 << eb);
                            leaf_we    = 1'b1;
                            leaf_wdata = new_leaf;
                            if (new_leaf == '0) begin
                                new_mid   = mid_rdata & ~(32'd1 << el);
                                mid_we    = 1'b1;
                                mid_wdata = new_mid;
                                if (new_mid == '0) n_top = r_top & ~(32'd1 << em);
                            end
                            n_count = r_count + 16'd1;
                        end
                    end
                    K_GIVE: begin
                        if (leaf_rdata[eb]) begin
                            n_st = ST_NOT_USED;
                        end else begin
                            leaf_we    = 1'b1;
                            leaf_wdata = leaf_rdata | (32'd1 << eb);
                            mid_we     = 1'b1;
                            mid_wdata  = mid_rdata | (32'd1 << el);
                            n_top      = r_top | (32'd1 << em);
                            n_count    = r_count - 16'd1;
                        end
                    end
                    default: n_free = leaf_rdata[eb];
                endcase
            end
            S_SWEEP: begin
                leaf_we    = 1'b1;
                leaf_waddr = r_sweep;
                leaf_wdata = '1;
                mid_we     = 32'(r_sweep) < MID_DEPTH;
                mid_waddr  = MAW'(r_sweep);
                mid_wdata  = '1;
                n_top      = '1;
                n_count    = '0;
                n_sweep    = r_sweep + LAW'(1);
                if (32'(r_sweep) == LEAF_DEPTH - 1) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_st;
                    n_o_granted = r_granted;
                    n_o_free    = r_free;
                    n_o_count   = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_m         <= n_m;
        r_l         <= n_l;
        r_mid_word  <= n_mid_word;
        r_st        <= n_st;
        r_granted   <= n_granted;
        r_free      <= n_free;
        r_o_status  <= n_o_status;
        r_o_granted <= n_o_granted;
        r_o_free    <= n_o_free;
        r_o_count   <= n_o_count;
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_init      <= 1'b1;
            r_sweep     <= '0;
            r_top       <= '1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_sweep     <= n_sweep;
            r_top       <= n_top;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// ===== design/hierarchical_bitmap_allocator_unit.sv =====
// top level of the hierarchical free bitmap allocator
//
// channel    dir  handshake      payload
// i_cmd      in   valid/ready    command, slot_index
// o_res      out  valid/ready    status, granted_index, is_free, used_count
// i_cfg_*    in   write enable   entry_limit
//
// allocate any walks the top, middle and leaf read chain, then the result register;
// given index ops go straight to execute, range errors and unknown commands to the result
// clear all sweeps the leaf ram one word a cycle, setting the middle ram words alongside
// after reset the same sweep runs with i_cmd.ready low
// a two deep job queue keeps accepting while the result register is stalled, until it is full
`default_nettype none
module hierarchical_bitmap_allocator_unit #(
    parameter int CAPACITY = 32768
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    hba_cmd_if.sink          i_cmd,
    hba_res_if.source        o_res
);
    import hba_pkg::*;

    logic [15:0] r_entry_limit;
    logic        job_valid, job_pop, busy;
    t_job        job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= 16'h8000;
        end else if (i_cfg_we) begin
            r_entry_limit <= i_cfg_wdata;
        end
    end

    hba_front #(.CAPACITY(CAPACITY)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd), .i_entry_limit(r_entry_limit),
        .i_busy(busy), .o_job_valid(job_valid), .o_job(job), .i_job_pop(job_pop)
    );

    hba_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid), .i_job(job),
        .o_job_pop(job_pop), .o_busy(busy), .o_res(o_res)
    );

    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> job_valid) else $error("job popped from empty queue");

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !(i_cmd.valid && i_cmd.ready)) else $error("command taken during init");

    a_free_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_free) |-> (o_res.status == ST_OK))
        else $error("is_free set on failed command");
endmodule
`default_nettype wire

// ===== tb/hierarchical_bitmap_allocator_unit_tb.sv =====
// testbench for the hierarchical bitmap allocator: directed and random commands against a behavioral tree model
`timescale 1ns / 1ps
`default_nettype none
module hierarchical_bitmap_allocator_unit_tb;
    import hba_pkg::*;

    localparam int CAP        = 32768;
    localparam int LEAF_WORDS = CAP / WORD_BITS;
    localparam int MID_WORDS  = LEAF_WORDS / WORD_BITS;
    localparam int CMD_JUNK   = 5;  // first command code with no meaning

    typedef struct packed {
        t_status     status;
        logic [14:0] granted;
        logic        free_bit;
        logic [15:0] used;
    } t_answer;

    // allocator tree model with its queue of pending answers
    class alloc_tracker;
        logic [31:0] leaf [LEAF_WORDS];
        logic [31:0] mid [MID_WORDS];
        logic [31:0] top;
        int unsigned total;
        int unsigned limit;
        t_answer     pending [$];
        int          errors;

        function void fill();
            foreach (leaf[i]) leaf[i] = '1;
            foreach (mid[i]) mid[i] = '1;
            top   = '1;
            total = 0;
        endfunction

        function int lowest(logic [31:0] w);
            for (int i = 0; i < 32; i++) if (w[i]) return i;
            return 0;
        endfunction

        function void take(int g);
            int l;
            l = g / 32;
            leaf[l][g % 32] = 1'b0;
            if (leaf[l] == 0) begin
                mid[l / 32][l % 32] = 1'b0;
                if (mid[l / 32] == 0) top[l / 32] = 1'b0;
            end
        endfunction

        function void note_command(logic [2:0] cmd, logic [14:0] idx);
            t_answer a;
            int unsigned lim;
            int m, l, g;
            lim = limit > CAP ? CAP : limit;
            a = '{ST_OK, idx, 1'b0, 16'd0};
            case (cmd)
                CMD_ANY: begin
                    if (total >= lim || top == 0) a.status = ST_FULL;
                    else begin
                        m = lowest(top);
                        l = m * 32 + lowest(mid[m]);
                        g = l * 32 + lowest(leaf[l]);
                        take(g);
                        total++;
                        a.granted = g[14:0];
                    end
                end
                CMD_TAKE: begin
                    if (idx >= lim) a.status = ST_RANGE;
                    else if (!leaf[idx / 32][idx % 32]) a.status = ST_USED;
                    else begin
                        take(idx);
                        total++;
                    end
                end
                CMD_GIVE: begin
                    if (idx >= lim) a.status = ST_RANGE;
                    else if (leaf[idx / 32][idx % 32]) a.status = ST_NOT_USED;
                    else begin
                        leaf[idx / 32][idx % 32] = 1'b1;
                        mid[idx / 1024][(idx / 32) % 32] = 1'b1;
                        top[idx / 1024] = 1'b1;
                        total--;
                    end
                end
                CMD_QUERY: begin
                    if (idx >= lim) a.status = ST_RANGE;
                    else a.free_bit = leaf[idx / 32][idx % 32];
                end
                CMD_CLEAR: fill();
                default: ;
            endcase
            a.used = total[15:0];
            pending.push_back(a);
        endfunction

        function void check_answer(t_answer got);
            t_answer e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item status=%0d", $time, got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.granted !== e.granted) begin
                $display("%0t: granted_index exp %0d got %0d", $time, e.granted, got.granted);
                errors++;
            end
            if (got.free_bit !== e.free_bit) begin
                $display("%0t: is_free exp %0d got %0d", $time, e.free_bit, got.free_bit);
                errors++;
            end
            if (got.used !== e.used) begin
                $display("%0t: used_count exp %0d got %0d", $time, e.used, got.used);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    hba_cmd_if   cmd_ch ();
    hba_res_if   res_ch ();

    hierarchical_bitmap_allocator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_cmd      (cmd_ch.sink),
        .o_res      (res_ch.source)
    );

    alloc_tracker tracker;
    bit           calm;        // no idling in the last part
    int unsigned  cycle_count;
    localparam int unsigned CYCLE_LIMIT = 4000000;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stall bursts, check on every accepted item
    initial begin
        int hold;
        hold = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready)
                tracker.check_answer({t_status'(res_ch.status), res_ch.granted_index,
                                      res_ch.is_free, res_ch.used_count});
            if (hold > 0) hold--;
            else if (!calm && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 14);
            res_ch.ready <= (hold == 0);
        end
    end

    // valid stays high from one item to the next unless an idle burst comes in between
    task automatic send(logic [2:0] cmd, logic [14:0] idx);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.command    <= cmd;
        cmd_ch.slot_index <= idx;
        do @(posedge i_clk); while (!cmd_ch.ready);
        tracker.note_command(cmd, idx);
    endtask

    task automatic write_limit(logic [15:0] val);
        cmd_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.limit = val;
    endtask

    // mostly in-range indices, some beyond the limit, some in the lowest leaf word
    function automatic logic [14:0] pick_index();
        int unsigned lim;
        lim = tracker.limit > CAP ? CAP : tracker.limit;
        case ($urandom_range(0, 9))
            0: return 15'($urandom);
            1: return 15'($urandom_range(0, 31));
            default: return (lim == 0) ? 15'($urandom) : 15'($urandom_range(0, lim - 1));
        endcase
    endfunction

    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) send(CMD_ANY, 15'($urandom));
            else if (r < 55) send(CMD_TAKE, pick_index());
            else if (r < 80) send(CMD_GIVE, pick_index());
            else if (r < 95) send(CMD_QUERY, pick_index());
            else if (r < 98) send(3'($urandom_range(CMD_JUNK, 7)), pick_index());
            else send(CMD_CLEAR, pick_index());
        end
    endtask

    initial begin
        tracker = new();
        tracker.fill();
        tracker.limit = 32768;
        calm         = 1'b0;
        cycle_count  = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command    = '0;
        cmd_ch.slot_index = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges at full capacity
        send(CMD_QUERY, 15'd0);
        send(CMD_ANY, 15'd0);
        send(CMD_ANY, 15'h7FFF);
        send(CMD_TAKE, 15'h7FFF);
        send(CMD_TAKE, 15'h7FFF);
        send(CMD_QUERY, 15'h7FFF);
        send(CMD_GIVE, 15'h7FFF);
        send(CMD_GIVE, 15'h7FFF);
        send(CMD_GIVE, 15'd5);
        send(3'd5, 15'h5555);
        send(3'd7, 15'h2AAA);
        send(CMD_CLEAR, 15'd0);
        // tiny limit: fill up, full, out of range
        write_limit(16'd3);
        for (int k = 0; k < 4; k++) send(CMD_ANY, 15'd0);
        send(CMD_TAKE, 15'd3);
        send(CMD_GIVE, 15'd3);
        send(CMD_QUERY, 15'd3);
        send(CMD_GIVE, 15'd1);
        send(CMD_ANY, 15'd0);
        // zero limit and above-capacity limit
        write_limit(16'd0);
        send(CMD_ANY, 15'd0);
        send(CMD_QUERY, 15'd0);
        write_limit(16'hFFFF);
        send(CMD_QUERY, 15'h7FFF);

        // small limits reach the full table and leaf/middle word emptying
        write_limit(16'd40);
        random_phase(120);
        write_limit(16'd1);
        random_phase(30);
        write_limit(16'd1100);
        random_phase(130);
        write_limit(16'd32768);
        random_phase(120);
        calm = 1'b1;
        write_limit(16'd64);
        random_phase(100);

        cmd_ch.valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (tracker.errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== hierarchical_bitmap_allocator_unit.f =====
design/hba_pkg.sv
design/hba_cmd_if.sv
design/hba_res_if.sv
design/hba_ram.sv
design/hba_front.sv
design/hba_back.sv
design/hierarchical_bitmap_allocator_unit.sv
tb/hierarchical_bitmap_allocator_unit_tb.sv
